// ===== src/tlfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfb_pkg: shared types and constants of the two-level free block cache
// Field widths, request and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package tlfb_pkg;

	// fixed field widths of the request and response transfers
	localparam int ACTION_W = 2;
	localparam int CLASS_W  = 3;
	localparam int BLOCK_W  = 32;
	localparam int STATUS_W = 2;
	localparam int BATCH_W  = 6;

	localparam logic [BATCH_W-1:0] BATCH_RESET = 6'd16;

	// parameter defaults; the global pool is four times the local stack
	localparam int NUM_CLASSES_DEF  = 8;
	localparam int LOCAL_DEPTH_DEF  = 32;
	localparam int GLOBAL_DEPTH_DEF = 4 * LOCAL_DEPTH_DEF;
	localparam int ADDR_WIDTH_DEF   = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_GET   = 2'd0,
		ACT_PUT   = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_DROPPED = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

endpackage

// ===== src/tlfb_ram.sv =====
// ----------------------------------------------------------------------------
// tlfb_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlfb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/two_level_free_block_cache_unit.sv =====
// ----------------------------------------------------------------------------
// two_level_free_block_cache_unit: per-class free block cache, local + global
// Put, unused action and bad class answer from the execute state; a get
// hit reads the local stack and answers from the response state; a get
// miss refills from the global pool first, and a flush pushes the local
// stack into the global pool. One request is in hand at a time.
// Refill and flush move one entry per cycle through the stack memory ports.
// Reset clears all counts at once; the stack memories need no clearing pass.
// ----------------------------------------------------------------------------
module two_level_free_block_cache_unit #(
	parameter int NUM_CLASSES  = tlfb_pkg::NUM_CLASSES_DEF,
	parameter int LOCAL_DEPTH  = tlfb_pkg::LOCAL_DEPTH_DEF,
	parameter int GLOBAL_DEPTH = tlfb_pkg::GLOBAL_DEPTH_DEF,
	parameter int ADDR_WIDTH   = tlfb_pkg::ADDR_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [tlfb_pkg::ACTION_W-1:0] action,
	input  logic [tlfb_pkg::CLASS_W-1:0]  size_class,
	input  logic [tlfb_pkg::BLOCK_W-1:0]  block_address,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [tlfb_pkg::BLOCK_W-1:0]  result_address,
	output logic [tlfb_pkg::STATUS_W-1:0] status,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tlfb_pkg::BATCH_W-1:0]  refill_batch
);

	// ------------------------------------------------------------------
	// Derived widths
	// ------------------------------------------------------------------
	localparam int CW     = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
	localparam int XW     = CW > tlfb_pkg::CLASS_W ? CW : tlfb_pkg::CLASS_W;
	localparam int LIW    = LOCAL_DEPTH > 1 ? $clog2(LOCAL_DEPTH) : 1;
	localparam int LCW    = $clog2(LOCAL_DEPTH + 1);
	localparam int GIW    = GLOBAL_DEPTH > 1 ? $clog2(GLOBAL_DEPTH) : 1;
	localparam int GCW    = $clog2(GLOBAL_DEPTH + 1);
	localparam int LDEPTH = NUM_CLASSES * LOCAL_DEPTH;
	localparam int GDEPTH = NUM_CLASSES * GLOBAL_DEPTH;
	localparam int LMA    = LDEPTH > 1 ? $clog2(LDEPTH) : 1;
	localparam int GMA    = GDEPTH > 1 ? $clog2(GDEPTH) : 1;
	localparam int BW     = tlfb_pkg::BATCH_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_REFILL = 6'b000100,
		S_POP    = 6'b001000,
		S_RESP   = 6'b010000,
		S_FLUSH  = 6'b100000
	} state_t;

	// flat memory address of slot idx of class cls
	function automatic logic [LMA-1:0] local_addr(logic [CW-1:0] cls, logic [LIW-1:0] idx);
		local_addr = LMA'(cls) * LMA'(LOCAL_DEPTH) + LMA'(idx);
	endfunction

	function automatic logic [GMA-1:0] global_addr(logic [CW-1:0] cls, logic [GIW-1:0] idx);
		global_addr = GMA'(cls) * GMA'(GLOBAL_DEPTH) + GMA'(idx);
	endfunction

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	state_t                state_q, state_d;
	tlfb_pkg::action_t     act_q;
	logic [CW-1:0]         cls_q;
	logic                  cvalid_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [LCW-1:0]        lc_q, lc_d;
	logic [GCW-1:0]        gc_q, gc_d;
	logic [BW-1:0]         left_q, left_d;
	logic                  pend_q, pend_d;
	logic [LIW-1:0]        wr_idx_q, wr_idx_d;
	logic                  drop_q, drop_d;
	logic [BW-1:0]         batch_q;

	logic [LCW-1:0]        lcnt_q [NUM_CLASSES];
	logic [GCW-1:0]        gcnt_q [NUM_CLASSES];

	logic                          rsp_valid_q;
	logic [tlfb_pkg::BLOCK_W-1:0]  result_q;
	tlfb_pkg::status_t             status_q;

	// ------------------------------------------------------------------
	// Memory ports
	// ------------------------------------------------------------------
	logic                  lwr_en, lrd_en, gwr_en, grd_en;
	logic [LIW-1:0]        lwr_idx, lrd_idx;
	logic [GIW-1:0]        gwr_idx, grd_idx;
	logic [ADDR_WIDTH-1:0] lwr_data, gwr_data, lrd_data, grd_data;

	tlfb_ram #(
		.DEPTH (LDEPTH),
		.WIDTH (ADDR_WIDTH)
	) u_local_ram (
		.clk     (clk),
		.wr_en   (lwr_en),
		.wr_addr (local_addr(cls_q, lwr_idx)),
		.wr_data (lwr_data),
		.rd_en   (lrd_en),
		.rd_addr (local_addr(cls_q, lrd_idx)),
		.rd_data (lrd_data)
	);

	tlfb_ram #(
		.DEPTH (GDEPTH),
		.WIDTH (ADDR_WIDTH)
	) u_global_ram (
		.clk     (clk),
		.wr_en   (gwr_en),
		.wr_addr (global_addr(cls_q, gwr_idx)),
		.wr_data (gwr_data),
		.rd_en   (grd_en),
		.rd_addr (global_addr(cls_q, grd_idx)),
		.rd_data (grd_data)
	);

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	logic          req_accept;
	logic          slot_free;
	logic [XW-1:0] cls_wide;
	logic          cvalid_in;
	logic [CW-1:0] cls_in;

	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	// the response register may be reloaded when empty or being drained
	assign slot_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready  = 1'b1;

	assign cls_wide  = XW'(size_class);
	assign cvalid_in = (int'(size_class) < NUM_CLASSES);
	assign cls_in    = cvalid_in ? cls_wide[CW-1:0] : '0;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic                         fin;
	logic [tlfb_pkg::BLOCK_W-1:0] fin_addr;
	tlfb_pkg::status_t            fin_status;
	logic [LCW-1:0]               lc_m1;
	logic [GCW-1:0]               gc_m1;
	logic                         lc_room, gc_room, issue;

	assign lc_m1   = lc_q - LCW'(1);
	assign gc_m1   = gc_q - GCW'(1);
	assign lc_room = (lc_q < LCW'(LOCAL_DEPTH));
	assign gc_room = (gc_q < GCW'(GLOBAL_DEPTH));

	always_comb begin
		state_d    = state_q;
		lc_d       = lc_q;
		gc_d       = gc_q;
		left_d     = left_q;
		pend_d     = pend_q;
		wr_idx_d   = wr_idx_q;
		drop_d     = drop_q;
		lwr_en     = 1'b0;
		lwr_idx    = lc_q[LIW-1:0];
		lwr_data   = addr_q;
		lrd_en     = 1'b0;
		lrd_idx    = lc_m1[LIW-1:0];
		gwr_en     = 1'b0;
		gwr_idx    = gc_q[GIW-1:0];
		gwr_data   = addr_q;
		grd_en     = 1'b0;
		grd_idx    = gc_m1[GIW-1:0];
		fin        = 1'b0;
		fin_addr   = '0;
		fin_status = tlfb_pkg::ST_DONE;
		issue      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					// take a working copy of the class's counts
					lc_d    = lcnt_q[cls_in];
					gc_d    = gcnt_q[cls_in];
					state_d = S_EXEC;
				end
			end

			S_EXEC: begin
				unique case (act_q)
					tlfb_pkg::ACT_GET: begin
						if (!cvalid_q) begin
							fin        = slot_free;
							fin_status = tlfb_pkg::ST_EMPTY;
						end else if (lc_q != '0) begin
							// hit: read the top entry straight away
							lrd_en  = 1'b1;
							lc_d    = lc_m1;
							state_d = S_RESP;
						end else begin
							left_d  = batch_q;
							pend_d  = 1'b0;
							state_d = S_REFILL;
						end
					end
					tlfb_pkg::ACT_PUT: begin
						fin = slot_free;
						if (!cvalid_q) begin
							fin_status = tlfb_pkg::ST_DROPPED;
						end else if (lc_room) begin
							lwr_en = slot_free;
							if (slot_free) begin
								lc_d = lc_q + LCW'(1);
							end
						end else if (gc_room) begin
							gwr_en = slot_free;
							if (slot_free) begin
								gc_d = gc_q + GCW'(1);
							end
						end else begin
							fin_status = tlfb_pkg::ST_DROPPED;
						end
					end
					tlfb_pkg::ACT_FLUSH: begin
						if (!cvalid_q) begin
							fin = slot_free;
						end else begin
							pend_d  = 1'b0;
							drop_d  = 1'b0;
							state_d = S_FLUSH;
						end
					end
					default: begin
						fin = slot_free;
					end
				endcase
			end

			S_REFILL: begin
				// write back the entry read in the previous cycle
				lwr_en   = pend_q;
				lwr_idx  = wr_idx_q;
				lwr_data = grd_data;
				issue    = (left_q != '0) && (gc_q != '0) && lc_room;
				if (issue) begin
					grd_en   = 1'b1;
					gc_d     = gc_m1;
					lc_d     = lc_q + LCW'(1);
					left_d   = left_q - BW'(1);
					wr_idx_d = lc_q[LIW-1:0];
				end
				pend_d = issue;
				if (!issue && !pend_q) begin
					state_d = S_POP;
				end
			end

			S_POP: begin
				if (lc_q == '0) begin
					fin        = slot_free;
					fin_status = tlfb_pkg::ST_EMPTY;
				end else begin
					lrd_en  = 1'b1;
					lc_d    = lc_m1;
					state_d = S_RESP;
				end
			end

			S_RESP: begin
				fin      = slot_free;
				fin_addr = tlfb_pkg::BLOCK_W'(lrd_data);
			end

			S_FLUSH: begin
				// push the entry read last cycle, or drop it on a full pool
				gwr_data = lrd_data;
				if (pend_q) begin
					if (gc_room) begin
						gwr_en = 1'b1;
						gc_d   = gc_q + GCW'(1);
					end else begin
						drop_d = 1'b1;
					end
				end
				issue = (lc_q != '0);
				if (issue) begin
					lrd_en = 1'b1;
					lc_d   = lc_m1;
				end
				pend_d = issue;
				if (!issue && !pend_q) begin
					fin        = slot_free;
					fin_status = drop_q ? tlfb_pkg::ST_DROPPED : tlfb_pkg::ST_DONE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			state_d = S_IDLE;
		end
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			drop_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			batch_q     <= tlfb_pkg::BATCH_RESET;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				lcnt_q[i] <= '0;
				gcnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			drop_q  <= drop_d;
			if (cfg_valid && cfg_ready) begin
				batch_q <= refill_batch;
			end
			// commit the working counts while a request is in hand
			if (state_q != S_IDLE && cvalid_q) begin
				lcnt_q[cls_q] <= lc_d;
				gcnt_q[cls_q] <= gc_d;
			end
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_accept) begin
			act_q    <= tlfb_pkg::action_t'(action);
			cls_q    <= cls_in;
			cvalid_q <= cvalid_in;
			addr_q   <= ADDR_WIDTH'(block_address);
		end
		lc_q     <= lc_d;
		gc_q     <= gc_d;
		left_q   <= left_d;
		wr_idx_q <= wr_idx_d;
		if (fin) begin
			result_q <= fin_addr;
			status_q <= fin_status;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign result_address = result_q;
	assign status         = status_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for two_level_free_block_cache_unit
// Feeds get, put, flush and unused requests through the valid/stall request
// channel with random gaps, stalls the response channel at random, and checks
// every response against a cycle-free shadow of the per-class local stacks and
// global pools. The refill batch register is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          CLASSES       = tlfb_pkg::NUM_CLASSES_DEF;
	localparam int          LOCAL_SLOTS   = tlfb_pkg::LOCAL_DEPTH_DEF;
	localparam int          POOL_SLOTS    = tlfb_pkg::GLOBAL_DEPTH_DEF;
	// settle time; the longest response is a get miss that refills a full local stack
	localparam int          SETTLE_CYCLES = 48;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	typedef struct {
		tlfb_pkg::action_t                 act;
		logic [tlfb_pkg::CLASS_W-1:0]      cls;
		logic [tlfb_pkg::BLOCK_W-1:0]      addr;
	} request_t;

	typedef struct {
		logic [tlfb_pkg::BLOCK_W-1:0]      addr;
		tlfb_pkg::status_t                 st;
	} reply_t;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	logic [tlfb_pkg::ACTION_W-1:0] action;
	logic [tlfb_pkg::CLASS_W-1:0]  size_class;
	logic [tlfb_pkg::BLOCK_W-1:0]  block_address;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [tlfb_pkg::BLOCK_W-1:0]  result_address;
	logic [tlfb_pkg::STATUS_W-1:0] status;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [tlfb_pkg::BATCH_W-1:0]  refill_batch;

	two_level_free_block_cache_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.action         (action),
		.size_class     (size_class),
		.block_address  (block_address),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.result_address (result_address),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.refill_batch   (refill_batch)
	);

	// ------------------------------------------------------------------
	// Shadow of the cache: per-class local stack and global pool, kept in
	// step with every accepted request.
	// ------------------------------------------------------------------
	logic [tlfb_pkg::BLOCK_W-1:0] cached_blocks [CLASSES][LOCAL_SLOTS];
	int unsigned                  cached_count  [CLASSES];
	logic [tlfb_pkg::BLOCK_W-1:0] pooled_blocks [CLASSES][POOL_SLOTS];
	int unsigned                  pooled_count  [CLASSES];
	int unsigned                  batch_setting;

	request_t    pending_requests [$];
	reply_t      awaited_replies  [$];

	bit          failed;
	int unsigned cycle_count;

	// driver and monitor hand-over flags: set at the rising edge, consumed at
	// the falling edge, so the two never meet in one time step
	bit          req_taken;
	bit          rsp_taken;
	bit          holding;
	int unsigned send_wait;
	int unsigned stall_left;
	bit          send_calm;
	bit          recv_calm;
	int unsigned send_run;
	int unsigned recv_run;

	// Work out the response to one request and advance the shadow state.
	function automatic void serve_request(tlfb_pkg::action_t act, int unsigned c,
			logic [tlfb_pkg::BLOCK_W-1:0] blk);
		reply_t      r;
		int unsigned moved;
		r.addr = '0;
		r.st   = tlfb_pkg::ST_DONE;
		unique case (act)
			tlfb_pkg::ACT_GET: begin
				// miss: pull up to a batch from the top of the pool, one at a time
				if (cached_count[c] == 0) begin
					moved = 0;
					while (moved < batch_setting && pooled_count[c] > 0 &&
							cached_count[c] < LOCAL_SLOTS) begin
						pooled_count[c]--;
						cached_blocks[c][cached_count[c]] = pooled_blocks[c][pooled_count[c]];
						cached_count[c]++;
						moved++;
					end
				end
				if (cached_count[c] > 0) begin
					cached_count[c]--;
					r.addr = cached_blocks[c][cached_count[c]];
				end else begin
					r.st = tlfb_pkg::ST_EMPTY;
				end
			end
			tlfb_pkg::ACT_PUT: begin
				if (cached_count[c] < LOCAL_SLOTS) begin
					cached_blocks[c][cached_count[c]] = blk;
					cached_count[c]++;
				end else if (pooled_count[c] < POOL_SLOTS) begin
					pooled_blocks[c][pooled_count[c]] = blk;
					pooled_count[c]++;
				end else begin
					r.st = tlfb_pkg::ST_DROPPED;
				end
			end
			tlfb_pkg::ACT_FLUSH: begin
				// drain top first; whatever the pool cannot take is lost
				while (cached_count[c] > 0) begin
					cached_count[c]--;
					if (pooled_count[c] < POOL_SLOTS) begin
						pooled_blocks[c][pooled_count[c]] = cached_blocks[c][cached_count[c]];
						pooled_count[c]++;
					end else begin
						r.st = tlfb_pkg::ST_DROPPED;
					end
				end
			end
			default: ;
		endcase
		awaited_replies.push_back(r);
	endfunction

	// Wait before the next transfer; each run is drawn at random as calm (no
	// idling) or as random waits.
	function automatic int unsigned next_wait(ref bit calm, ref int unsigned run_left);
		if (run_left == 0) begin
			calm     = ($urandom_range(0, 2) == 0);
			run_left = $urandom_range(5, 30);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Request driver: advance through the pending queue at falling edges,
	// hold each payload until its transfer is seen.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		request_t item;
		if (arst_n) begin
			if (req_taken) begin
				req_taken = 1'b0;
				holding   = 1'b0;
				send_wait = next_wait(send_calm, send_run);
			end
			if (!holding && send_wait != 0) begin
				send_wait--;
			end else if (!holding && pending_requests.size() != 0) begin
				item          = pending_requests.pop_front();
				holding       = 1'b1;
				action        <= item.act;
				size_class    <= item.cls;
				block_address <= item.addr;
			end
			// one assignment per step, so back-to-back items keep valid high
			req_valid <= holding;
		end
	end

	// ------------------------------------------------------------------
	// Response stall: after each transfer draw a fresh stall length and
	// count it down only while a response is offered.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken) begin
				rsp_taken  = 1'b0;
				stall_left = next_wait(recv_calm, recv_run);
			end
			rsp_stall <= (stall_left != 0);
			if (stall_left != 0 && rsp_valid)
				stall_left--;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both channels at the rising edge. Check responses
	// before predicting, so a response never meets its own request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		reply_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("two_level_free_block_cache_unit test failed");
			$finish;
		end else if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_replies.size() == 0) begin
					$error("unexpected response: result_address %h status %0d",
						result_address, status);
					failed = 1'b1;
				end else begin
					want = awaited_replies.pop_front();
					if (result_address !== want.addr) begin
						$error("result_address: expected %h, got %h", want.addr, result_address);
						failed = 1'b1;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						failed = 1'b1;
					end
				end
				rsp_taken = 1'b1;
			end
			if (req_valid && !req_stall) begin
				serve_request(tlfb_pkg::action_t'(action), int'(size_class), block_address);
				req_taken = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_request(input tlfb_pkg::action_t act, input int unsigned c,
			input logic [tlfb_pkg::BLOCK_W-1:0] addr);
		request_t item;
		item.act  = act;
		item.cls  = c[tlfb_pkg::CLASS_W-1:0];
		item.addr = addr;
		pending_requests.push_back(item);
	endtask

	// Hold until every request has gone and every response has come, then
	// let the block settle.
	task automatic wait_for_quiet();
		@(posedge clk);
		while (pending_requests.size() != 0 || holding || awaited_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the refill batch register; only called while the block is idle.
	task automatic set_refill_batch(input logic [tlfb_pkg::BATCH_W-1:0] value);
		@(negedge clk);
		cfg_valid    <= 1'b1;
		refill_batch <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		batch_setting = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Bursts of puts or gets on a favoured class, flushes, and random noise.
	// The pick thresholds (out of ten) steer the phase towards filling or
	// draining the stacks.
	task automatic queue_random_phase(input int unsigned n_items, input int unsigned hot,
			input int unsigned put_cut, input int unsigned get_cut,
			input int unsigned flush_cut);
		int unsigned made;
		int unsigned pick;
		int unsigned burst;
		int unsigned c;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(0, 9);
			c    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CLASSES - 1) : hot;
			if (pick < put_cut) begin
				burst = $urandom_range(1, 40);
				repeat (burst) queue_request(tlfb_pkg::ACT_PUT, c, $urandom);
				made += burst;
			end else if (pick < get_cut) begin
				burst = $urandom_range(1, 24);
				repeat (burst) queue_request(tlfb_pkg::ACT_GET, c, $urandom);
				made += burst;
			end else if (pick < flush_cut) begin
				queue_request(tlfb_pkg::ACT_FLUSH, c, $urandom);
				made++;
			end else begin
				queue_request(tlfb_pkg::action_t'($urandom_range(0, 3)),
					$urandom_range(0, CLASSES - 1), $urandom);
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned hot;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		rsp_stall     = 1'b0;
		action        = tlfb_pkg::ACT_GET;
		size_class    = '0;
		block_address = '0;
		cfg_valid     = 1'b0;
		refill_batch  = '0;
		failed        = 1'b0;
		cycle_count   = 0;
		req_taken     = 1'b0;
		rsp_taken     = 1'b0;
		holding       = 1'b0;
		send_wait     = 0;
		stall_left    = 0;
		send_calm     = 1'b0;
		recv_calm     = 1'b0;
		send_run      = 0;
		recv_run      = 0;
		batch_setting = tlfb_pkg::BATCH_RESET;
		for (int c = 0; c < CLASSES; c++) begin
			cached_count[c] = 0;
			pooled_count[c] = 0;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset batch: empty get, unused action, address
		// extremes, LIFO order, flush of an empty class, flush then refill
		queue_request(tlfb_pkg::ACT_GET,   0, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_NOP,   7, 32'hFFFF_FFFF);
		queue_request(tlfb_pkg::ACT_PUT,   7, 32'hFFFF_FFFF);
		queue_request(tlfb_pkg::ACT_PUT,   7, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_GET,   7, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_GET,   7, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_GET,   7, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_FLUSH, 3, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_PUT,   0, 32'hA5A5_5A5A);
		queue_request(tlfb_pkg::ACT_PUT,   0, 32'h1234_5678);
		queue_request(tlfb_pkg::ACT_PUT,   0, 32'h8000_0001);
		queue_request(tlfb_pkg::ACT_FLUSH, 0, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_GET,   0, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_GET,   0, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_NOP,   0, 32'h0000_0000);
		wait_for_quiet();

		// zero batch: a miss moves nothing, so the get reports empty even
		// though the pool holds blocks
		set_refill_batch(6'd0);
		queue_request(tlfb_pkg::ACT_PUT,   1, 32'hDEAD_0001);
		queue_request(tlfb_pkg::ACT_PUT,   1, 32'hDEAD_0002);
		queue_request(tlfb_pkg::ACT_FLUSH, 1, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_GET,   1, 32'h0000_0000);
		queue_request(tlfb_pkg::ACT_PUT,   1, 32'hDEAD_0003);
		queue_request(tlfb_pkg::ACT_GET,   1, 32'h0000_0000);
		wait_for_quiet();

		// growth on one class towards overflow of both levels, smallest batch
		hot = $urandom_range(0, CLASSES - 1);
		set_refill_batch(6'd1);
		queue_random_phase(150, hot, 6, 7, 9);
		wait_for_quiet();

		set_refill_batch(6'd32);
		queue_random_phase(100, hot, 6, 7, 9);
		wait_for_quiet();

		// drain with an oversized batch: refills stop at a full local stack
		// or an empty pool
		set_refill_batch(6'd63);
		queue_random_phase(100, hot, 2, 7, 8);
		wait_for_quiet();

		set_refill_batch(6'($urandom_range(0, 63)));
		queue_random_phase(100, $urandom_range(0, CLASSES - 1), 4, 7, 8);
		wait_for_quiet();

		if (!failed)
			$display("two_level_free_block_cache_unit test passed");
		else
			$display("two_level_free_block_cache_unit test failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/tlfb_pkg.sv
src/tlfb_ram.sv
src/two_level_free_block_cache_unit.sv
tb/testbench.sv
